[hw/rtl/dcsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcsm_pkg
// Shared types and codes of the debug call stack monitor: request and
// response words, frame layout, opcodes, frame kinds and the control
// interface between sequencer and datapath.
// ----------------------------------------------------------------------------
package dcsm_pkg;

   localparam logic [2:0] OP_BLOCK      = 3'd0;
   localparam logic [2:0] OP_SET_BREAK  = 3'd1;
   localparam logic [2:0] OP_SET_WATCH  = 3'd2;
   localparam logic [2:0] OP_CONTINUE   = 3'd3;
   localparam logic [2:0] OP_READ_FRAME = 3'd4;

   localparam logic [1:0] KIND_CALL      = 2'd0;
   localparam logic [1:0] KIND_RESTART   = 2'd1;
   localparam logic [1:0] KIND_INTERRUPT = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic        trap_call;
      logic        trap_restart;
      logic        trap_return;
      logic        trap_interrupt;
      logic [15:0] stack_pointer;
      logic [15:0] program_counter;
      logic [15:0] address;
      logic [7:0]  memory_byte;
      logic [5:0]  frame_index;
   } req_type;

   typedef struct packed {
      logic        halted;
      logic        break_hit;
      logic        watch_hit;
      logic [7:0]  watch_old_value;
      logic [7:0]  watch_new_value;
      logic [6:0]  depth;
      logic        overflowed;
      logic        frame_valid;
      logic [15:0] frame_pc;
      logic [15:0] frame_sp;
      logic [1:0]  frame_kind;
   } rsp_type;

   typedef struct packed {
      logic [15:0] sp;
      logic [15:0] pc;
      logic [1:0]  kind;
   } frame_type;

   typedef struct packed {
      logic       load;
      logic       push;
      logic [1:0] push_kind;
      logic       top_read;
      logic       pop;
      logic       frame_read;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       trap_call;
      logic       trap_restart;
      logic       trap_return;
      logic       trap_interrupt;
      logic       count_zero;
      logic       top_restart;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/debug_call_stack_monitor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// debug_call_stack_monitor
// Shadow call stack with one-shot breakpoint and watchpoint for a CPU debugger.
//
// The req_ channel carries one command word per executed block or debugger
// command; the rsp_ channel returns exactly one status word for each, in
// order. Both use valid/ready.
// A word is taken only when the sequencer is idle. The sequencer then works
// through the single-port frame memory, at most one access a cycle: a push per
// trap, a read of the top per frame a return pops, or one read for a frame
// query, and issues the result before it returns to idle.
// The response register lets a new word be accepted while the previous
// result still waits; if the receiver stalls longer, the sequencer holds in
// its final step until the register frees.
// Reset empties the stack, clears overflow and halt and disarms both points.
// ----------------------------------------------------------------------------
module debug_call_stack_monitor #(
   parameter int STACK_DEPTH = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  dcsm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output dcsm_pkg::rsp_type rsp_payload
);

   dcsm_pkg::cmd_type    cmd;
   dcsm_pkg::status_type status;

   dcsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dcsm_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

[hw/rtl/dcsm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcsm_ctrl
// Sequencer of the monitor: takes one request word, steps the shadow stack
// through the trap pushes and the return unwind or a frame read, then issues the result.
// ----------------------------------------------------------------------------
module dcsm_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  dcsm_pkg::status_type status,
   output dcsm_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_PUSH_CALL,
      S_PUSH_RST,
      S_RET_RD,
      S_RET_CHK,
      S_PUSH_INT,
      S_FRAME_RD,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type after_ret;
   state_type after_rst;
   state_type after_call;

   always_comb begin
      after_ret  = status.trap_interrupt ? S_PUSH_INT : S_FINISH;
      after_rst  = status.trap_return ? S_RET_RD : after_ret;
      after_call = status.trap_restart ? S_PUSH_RST : after_rst;
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.opcode == dcsm_pkg::OP_BLOCK) begin
               state_in = status.trap_call ? S_PUSH_CALL : after_call;
            end else if (status.opcode == dcsm_pkg::OP_READ_FRAME) begin
               state_in = S_FRAME_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PUSH_CALL: begin
            cmd.push      = 1'b1;
            cmd.push_kind = dcsm_pkg::KIND_CALL;
            state_in      = after_call;
         end
         S_PUSH_RST: begin
            cmd.push      = 1'b1;
            cmd.push_kind = dcsm_pkg::KIND_RESTART;
            state_in      = after_rst;
         end
         S_RET_RD: begin
            if (status.count_zero) begin
               state_in = after_ret;
            end else begin
               cmd.top_read = 1'b1;
               state_in     = S_RET_CHK;
            end
         end
         S_RET_CHK: begin
            cmd.pop  = 1'b1;
            state_in = status.top_restart ? S_RET_RD : after_ret;
         end
         S_PUSH_INT: begin
            cmd.push      = 1'b1;
            cmd.push_kind = dcsm_pkg::KIND_INTERRUPT;
            state_in      = S_FINISH;
         end
         S_FRAME_RD: begin
            cmd.frame_read = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/dcsm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcsm_datapath
// Shadow frame memory, stack count, break and watch points, halt flag and
// the response register.
// ----------------------------------------------------------------------------
module dcsm_datapath #(
   parameter int STACK_DEPTH = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  dcsm_pkg::req_type    req_payload,
   input  dcsm_pkg::cmd_type    cmd,
   output dcsm_pkg::status_type status,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output dcsm_pkg::rsp_type    rsp_payload
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = (CW > 6) ? CW : 6;

   dcsm_pkg::frame_type mem [STACK_DEPTH];

   dcsm_pkg::req_type   req_ff;
   dcsm_pkg::frame_type rd_data_ff;
   dcsm_pkg::rsp_type   rsp_ff;
   dcsm_pkg::rsp_type   rsp_in;
   logic                fvalid_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          overflow_ff;
   logic          overflow_in;
   logic [15:0]   break_addr_ff;
   logic [15:0]   break_addr_in;
   logic          break_armed_ff;
   logic          break_armed_in;
   logic          watch_armed_ff;
   logic          watch_armed_in;
   logic [7:0]    watch_value_ff;
   logic [7:0]    watch_value_in;
   logic          halt_ff;
   logic          halt_in;

   logic          full;
   logic [CW-1:0] top_cnt;
   logic [IW-1:0] idx_w;
   logic [IW-1:0] cnt_w;
   logic [IW-1:0] frame_pos;
   logic          frame_ok;
   logic [AW-1:0] rd_addr;
   logic          whit;
   logic          bhit;
   dcsm_pkg::frame_type wr_frame;

   assign full      = (count_ff == CW'(STACK_DEPTH));
   assign top_cnt   = count_ff - CW'(1);
   assign idx_w     = IW'(req_ff.frame_index);
   assign cnt_w     = IW'(count_ff);
   assign frame_ok  = (idx_w < cnt_w);
   assign frame_pos = cnt_w - idx_w - IW'(1);
   assign rd_addr   = cmd.frame_read ? frame_pos[AW-1:0] : top_cnt[AW-1:0];

   assign wr_frame.sp   = req_ff.stack_pointer;
   assign wr_frame.pc   = req_ff.program_counter;
   assign wr_frame.kind = cmd.push_kind;

   assign whit = watch_armed_ff && (req_ff.memory_byte != watch_value_ff);
   assign bhit = break_armed_ff && (req_ff.program_counter == break_addr_ff);

   always_comb begin
      status.opcode         = req_ff.opcode;
      status.trap_call      = req_ff.trap_call;
      status.trap_restart   = req_ff.trap_restart;
      status.trap_return    = req_ff.trap_return;
      status.trap_interrupt = req_ff.trap_interrupt;
      status.count_zero     = (count_ff == '0);
      status.top_restart    = (rd_data_ff.kind == dcsm_pkg::KIND_RESTART);
      status.out_free       = !rsp_valid_ff || rsp_ready;
   end

   // stack count and overflow
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.push) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.pop && (count_ff != '0)) begin
         count_in = top_cnt;
      end
   end

   // points, halt and response word
   always_comb begin
      break_addr_in  = break_addr_ff;
      break_armed_in = break_armed_ff;
      watch_armed_in = watch_armed_ff;
      watch_value_in = watch_value_ff;
      halt_in        = halt_ff;
      rsp_in         = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (req_ff.opcode)
            dcsm_pkg::OP_BLOCK: begin
               if (whit) begin
                  watch_armed_in         = 1'b0;
                  halt_in                = 1'b1;
                  rsp_in.watch_hit       = 1'b1;
                  rsp_in.watch_old_value = watch_value_ff;
                  rsp_in.watch_new_value = req_ff.memory_byte;
               end
               if (bhit) begin
                  break_armed_in   = 1'b0;
                  halt_in          = 1'b1;
                  rsp_in.break_hit = 1'b1;
               end
            end
            dcsm_pkg::OP_SET_BREAK: begin
               break_addr_in  = req_ff.address;
               break_armed_in = 1'b1;
            end
            dcsm_pkg::OP_SET_WATCH: begin
               watch_value_in = req_ff.memory_byte;
               watch_armed_in = 1'b1;
            end
            dcsm_pkg::OP_CONTINUE: begin
               halt_in = 1'b0;
            end
            dcsm_pkg::OP_READ_FRAME: begin
               if (fvalid_ff) begin
                  rsp_in.frame_valid = 1'b1;
                  rsp_in.frame_pc    = rd_data_ff.pc;
                  rsp_in.frame_sp    = rd_data_ff.sp;
                  rsp_in.frame_kind  = rd_data_ff.kind;
               end
            end
            default: begin
            end
         endcase
         rsp_in.halted     = halt_in;
         rsp_in.depth      = 7'(count_ff);
         rsp_in.overflowed = overflow_ff;
      end
   end

   // frame memory
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         mem[count_ff[AW-1:0]] <= wr_frame;
      end
      if (cmd.top_read || cmd.frame_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.frame_read) begin
         fvalid_ff <= frame_ok;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         break_addr_ff  <= '0;
         break_armed_ff <= 1'b0;
         watch_armed_ff <= 1'b0;
         watch_value_ff <= '0;
         halt_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         break_addr_ff  <= break_addr_in;
         break_armed_ff <= break_armed_in;
         watch_armed_ff <= watch_armed_in;
         watch_value_ff <= watch_value_in;
         halt_ff        <= halt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

[hw/rtl/dcsm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcsm_checker
// Port-level checks of the debug call stack monitor, bound to the top level.
// ----------------------------------------------------------------------------
module dcsm_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input dcsm_pkg::req_type req_payload,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input dcsm_pkg::rsp_type rsp_payload
);

   // one word at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped or changed while stalled");

   a_hit_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.break_hit || rsp_payload.watch_hit))
      |-> rsp_payload.halted)
      else $error("point hit without halt");

   a_watch_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.watch_hit)
      |-> (rsp_payload.watch_old_value == 8'd0 && rsp_payload.watch_new_value == 8'd0))
      else $error("watch values without a watch hit");

   a_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.frame_valid)
      |-> (rsp_payload.frame_pc == 16'd0 && rsp_payload.frame_sp == 16'd0
           && rsp_payload.frame_kind == 2'd0))
      else $error("frame fields without a valid frame");

endmodule

bind debug_call_stack_monitor dcsm_checker u_dcsm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
